### design/bfpca_pkg.sv
// Shared types and constants for the best-fit page chunk allocator.
package bfpca_pkg;

    localparam int CHUNK_SLOTS = 64;
    localparam int SLOT_W      = $clog2(CHUNK_SLOTS);
    localparam int USED_W      = $clog2(CHUNK_SLOTS + 1);
    localparam int PAGE_W      = 44;
    localparam int COUNT_W     = 20;
    localparam int SLOTS_OUT_W = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 44;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_NOFIT = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE  = 1'd0,
        CFG_POOL_COUNT = 1'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_RD,
        S_ALLOC_LAST,
        S_FREE_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic probe;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic cnt_zero;
        logic base_zero;
        logic idx_last;
        logic slot_free;
        logic out_free;
    } t_dp_status;

endpackage

### design/bfpca_datapath.sv
// Datapath: chunk table memory, valid bits, best-fit compare, counters, result register.
module bfpca_datapath
    import bfpca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_sts,
    input  logic [1:0]             i_op,
    input  logic [COUNT_W-1:0]     i_page_count,
    input  logic [PAGE_W-1:0]      i_base_page,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [1:0]             o_status,
    output logic [PAGE_W-1:0]      o_alloc_page,
    output logic [COUNT_W-1:0]     o_free_total,
    output logic [SLOTS_OUT_W-1:0] o_slots_used
);

    localparam int ENTRY_W = PAGE_W + COUNT_W;

    logic [ENTRY_W-1:0]     r_mem [CHUNK_SLOTS];
    logic [ENTRY_W-1:0]     r_rd_data;

    logic [PAGE_W-1:0]      r_pool_base;
    logic [COUNT_W-1:0]     r_pool_count;

    t_op                    r_op;
    logic [COUNT_W-1:0]     r_cnt;
    logic [PAGE_W-1:0]      r_base;

    logic [SLOT_W-1:0]      r_idx;
    logic                   r_cmp_pend;
    logic [SLOT_W-1:0]      r_cmp_idx;
    logic                   r_found;
    logic [SLOT_W-1:0]      r_best_idx;
    logic [PAGE_W-1:0]      r_best_start;
    logic [COUNT_W-1:0]     r_best_pages;

    logic [CHUNK_SLOTS-1:0] r_valid;
    logic [COUNT_W-1:0]     r_free_sum;
    logic [USED_W-1:0]      r_used;

    logic                   r_out_valid;
    t_status                r_status;
    logic [PAGE_W-1:0]      r_alloc_page;

    logic [PAGE_W-1:0]      rd_start;
    logic [COUNT_W-1:0]     rd_pages;
    logic                   cmp_hit;
    logic                   slot_free;
    logic [COUNT_W:0]       sum_ext;

    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]     wr_data;
    t_status                n_status;
    logic [PAGE_W-1:0]      n_alloc_page;
    logic [COUNT_W-1:0]     n_free_sum;
    logic [USED_W-1:0]      n_used;
    logic [CHUNK_SLOTS-1:0] n_valid;

    assign rd_start  = r_rd_data[ENTRY_W-1:COUNT_W];
    assign rd_pages  = r_rd_data[COUNT_W-1:0];
    assign slot_free = ~r_valid[r_idx];
    assign cmp_hit   = r_cmp_pend && r_valid[r_cmp_idx] && (rd_pages >= r_cnt) &&
                       (!r_found || (rd_pages < r_best_pages));
    assign sum_ext   = {1'b0, r_free_sum} + {1'b0, r_cnt};

    assign o_sts.op        = r_op;
    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.base_zero = (r_base == '0);
    assign o_sts.idx_last  = (r_idx == SLOT_W'(CHUNK_SLOTS - 1));
    assign o_sts.slot_free = slot_free;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // Chunk table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Outcome of the captured item, applied on commit.
    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = r_best_idx;
        wr_data      = {r_base, r_cnt};
        n_status     = ST_OK;
        n_alloc_page = '0;
        n_free_sum   = r_free_sum;
        n_used       = r_used;
        n_valid      = r_valid;
        case (r_op)
            OP_ALLOC: begin
                if (r_cnt == '0) begin
                    n_status = ST_BAD;
                end else if (!r_found) begin
                    n_status = ST_NOFIT;
                end else begin
                    n_alloc_page = r_best_start;
                    if (r_best_pages > r_cnt) begin
                        // shrink from the front
                        wr_en   = 1'b1;
                        wr_data = {r_best_start + PAGE_W'(r_cnt), r_best_pages - r_cnt};
                    end else begin
                        n_valid[r_best_idx] = 1'b0;
                        if (r_used != '0) begin
                            n_used = r_used - USED_W'(1);
                        end
                    end
                    n_free_sum = (r_free_sum >= r_cnt) ? (r_free_sum - r_cnt) : '0;
                end
            end
            OP_FREE: begin
                if ((r_cnt == '0) || (r_base == '0)) begin
                    n_status = ST_BAD;
                end else if (!r_found) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en               = 1'b1;
                    n_valid[r_best_idx] = 1'b1;
                    n_used              = r_used + USED_W'(1);
                    n_free_sum          = sum_ext[COUNT_W] ? '1 : sum_ext[COUNT_W-1:0];
                end
            end
            OP_INIT: begin
                n_valid    = '0;
                n_used     = '0;
                n_free_sum = '0;
                if (r_pool_count != '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = {r_pool_base, r_pool_count};
                    n_valid[0] = 1'b1;
                    n_used     = USED_W'(1);
                    n_free_sum = r_pool_count;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= '0;
            r_pool_count <= '0;
            r_valid      <= '0;
            r_free_sum   <= '0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_cmp_pend   <= 1'b0;
            r_found      <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_POOL_BASE:  r_pool_base  <= i_cfg_data[PAGE_W-1:0];
                    CFG_POOL_COUNT: r_pool_count <= i_cfg_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_cmp_pend <= i_cmd.rd_en;
            if (i_cmd.capture) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.rd_en || i_cmd.probe) begin
                    r_idx <= r_idx + SLOT_W'(1);
                end
                if (cmp_hit || (i_cmd.probe && slot_free && !r_found)) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_valid     <= n_valid;
                r_free_sum  <= n_free_sum;
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_op);
            r_cnt  <= i_page_count;
            r_base <= i_base_page;
        end
        if (i_cmd.rd_en) begin
            r_cmp_idx <= r_idx;
        end
        if (cmp_hit) begin
            r_best_idx   <= r_cmp_idx;
            r_best_start <= rd_start;
            r_best_pages <= rd_pages;
        end else if (i_cmd.probe && slot_free && !r_found) begin
            r_best_idx <= r_idx;
        end
        if (i_cmd.commit) begin
            r_status     <= n_status;
            r_alloc_page <= n_alloc_page;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_alloc_page = r_alloc_page;
    assign o_free_total = r_free_sum;
    assign o_slots_used = SLOTS_OUT_W'(r_used);

endmodule

### design/bfpca_ctrl.sv
// Controller: sequences capture, table scan and commit for each item.
module bfpca_ctrl
    import bfpca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_stall    = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if ((i_sts.op == OP_ALLOC) && !i_sts.cnt_zero) begin
                    n_state = S_ALLOC_RD;
                end else if ((i_sts.op == OP_FREE) && !i_sts.cnt_zero && !i_sts.base_zero) begin
                    n_state = S_FREE_SCAN;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_ALLOC_RD: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_ALLOC_LAST;
                end
            end
            S_ALLOC_LAST: begin
                // last slot's read data is compared in this cycle
                n_state = S_COMMIT;
            end
            S_FREE_SCAN: begin
                o_cmd.probe = 1'b1;
                if (i_sts.slot_free || i_sts.idx_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the result register can take the item
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/best_fit_page_chunk_allocator_unit.sv
// Top level of the best-fit page chunk allocator.
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid / o_in_stall i_op, i_page_count, i_base_page
//  result    out        o_out_valid / i_out_stall o_status, o_alloc_page,
//                                               o_free_total, o_slots_used
//  config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// Allocate steps through a decode state, one table read per slot through the single memory
// read port, a compare and a commit.
// Free probes valid bits lowest slot first and stops at the first free slot.
// Init, error and unknown items go from decode straight to commit. One item is in flight
// at a time; the next item can be taken in the cycle after the result is loaded.
// Reset clears the valid bits, counters and configuration.
// A stalled result holds the commit until the result register frees up.
module best_fit_page_chunk_allocator_unit
    import bfpca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_op,
    input  logic [COUNT_W-1:0]     i_page_count,
    input  logic [PAGE_W-1:0]      i_base_page,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic [PAGE_W-1:0]      o_alloc_page,
    output logic [COUNT_W-1:0]     o_free_total,
    output logic [SLOTS_OUT_W-1:0] o_slots_used,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status sts;

    bfpca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfpca_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_page_count (i_page_count),
        .i_base_page  (i_base_page),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_alloc_page (o_alloc_page),
        .o_free_total (o_free_total),
        .o_slots_used (o_slots_used)
    );

`ifndef SYNTHESIS
    a_commit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_out_valid || !i_out_stall))
        else $error("result committed over a stalled item");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("result valid without a commit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted while one is in flight");
`endif

endmodule
